// ===== rtl/lph_pkg.sv =====
package lph_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned CNT_W = 9;
  localparam logic [CNT_W-1:0] LIMIT_RESET = 9'd192;

  localparam logic [1:0] OP_SET = 2'd0;
  localparam logic [1:0] OP_GET = 2'd1;
  localparam logic [1:0] OP_DEL = 2'd2;
  localparam logic [1:0] OP_NEXT = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] key_id;
    logic [63:0] key_hash;
    logic [3:0]  value_tag;
    logic [63:0] value_data;
    logic [8:0]  cursor;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_key;
    logic [3:0]  found_tag;
    logic [63:0] found_data;
    logic [8:0]  next_cursor;
    logic [8:0]  live_count;
  } rsp_t;

  typedef struct packed {
    logic        used;
    logic        tomb;
    logic [31:0] key;
    logic [3:0]  tag;
    logic [63:0] data;
  } slot_t;

  typedef struct packed {
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    slot_t                wdata;
    logic                 re;
    logic [IDX_W-1:0]     raddr;
  } mem_req_t;

endpackage

// ===== rtl/lph_slot_mem.sv =====
module lph_slot_mem (
  input  logic             clk_i,
  input  lph_pkg::mem_req_t req_i,
  output lph_pkg::slot_t   rdata_o
);

  logic [31:0] key_mem  [lph_pkg::CAPACITY];
  logic [3:0]  tag_mem  [lph_pkg::CAPACITY];
  logic [63:0] data_mem [lph_pkg::CAPACITY];
  logic        used_mem [lph_pkg::CAPACITY];
  logic        tomb_mem [lph_pkg::CAPACITY];
  lph_pkg::slot_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      key_mem[req_i.waddr]  <= req_i.wdata.key;
      tag_mem[req_i.waddr]  <= req_i.wdata.tag;
      data_mem[req_i.waddr] <= req_i.wdata.data;
      used_mem[req_i.waddr] <= req_i.wdata.used;
      tomb_mem[req_i.waddr] <= req_i.wdata.tomb;
    end
    if (req_i.re) begin
      rd_q.key  <= key_mem[req_i.raddr];
      rd_q.tag  <= tag_mem[req_i.raddr];
      rd_q.data <= data_mem[req_i.raddr];
      rd_q.used <= used_mem[req_i.raddr];
      rd_q.tomb <= tomb_mem[req_i.raddr];
    end
  end

  assign rdata_o = rd_q;

endmodule

// ===== rtl/lph_ctrl.sv =====
module lph_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  lph_pkg::req_t     req_i,
  input  logic [8:0]        limit_i,
  output logic              busy,
  output logic              done_o,
  output lph_pkg::rsp_t     rsp_o,
  output lph_pkg::mem_req_t mem_o,
  input  lph_pkg::slot_t    slot_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_CLEAR = 2'd3;

  localparam int unsigned IW = lph_pkg::IDX_W;
  localparam int unsigned CW = lph_pkg::CNT_W;

  logic [1:0]    state_q, state_d;
  lph_pkg::req_t req_q;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] cur_q, cur_d;
  logic          tomb_v_q, tomb_v_d;
  logic [IW-1:0] tomb_q, tomb_d;
  logic [CW-1:0] live_q, live_d;
  logic          done_q, done_d;
  lph_pkg::rsp_t rsp_q, rsp_d;
  logic          fin;
  logic          hit;
  logic          have_free;
  logic [IW-1:0] free_idx;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    n_d      = n_q;
    cur_d    = cur_q;
    tomb_v_d = tomb_v_q;
    tomb_d   = tomb_q;
    live_d   = live_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    mem_o    = '0;
    fin      = 1'b0;
    hit      = 1'b0;
    have_free = 1'b0;
    free_idx = '0;
    case (state_q)
      S_CLEAR: begin
        // walk every slot once after reset, clearing used and tombstone flags
        mem_o.we = 1'b1;
        mem_o.waddr = n_q[IW-1:0];
        n_d = n_q + CW'(1);
        if (n_q == CW'(lph_pkg::CAPACITY - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          idx_d = req_i.key_hash[IW-1:0];
          n_d = '0;
          tomb_v_d = 1'b0;
          cur_d = req_i.cursor;
          if (req_i.operation == lph_pkg::OP_NEXT) begin
            if (req_i.cursor >= CW'(lph_pkg::CAPACITY)) begin
              rsp_d = '0;
              rsp_d.status = lph_pkg::ST_DONE;
              rsp_d.next_cursor = req_i.cursor;
              rsp_d.live_count = live_q;
              done_d = 1'b1;
            end else begin
              mem_o.re = 1'b1;
              mem_o.raddr = req_i.cursor[IW-1:0];
              state_d = S_SCAN;
            end
          end else begin
            mem_o.re = 1'b1;
            mem_o.raddr = req_i.key_hash[IW-1:0];
            state_d = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        rsp_d = '0;
        rsp_d.live_count = live_q;
        if (slot_i.used && slot_i.key == req_q.key_id) begin
          hit = 1'b1;
          fin = 1'b1;
        end else if (!slot_i.used && !slot_i.tomb) begin
          fin = 1'b1;
          have_free = 1'b1;
          free_idx = tomb_v_q ? tomb_q : idx_q;
        end else begin
          if (!slot_i.used && !tomb_v_q) begin
            tomb_v_d = 1'b1;
            tomb_d = idx_q;
          end
          if (n_q == CW'(lph_pkg::CAPACITY - 1)) begin
            fin = 1'b1;
            have_free = tomb_v_q || !slot_i.used;
            free_idx = tomb_v_q ? tomb_q : idx_q;
          end
        end
        if (fin) begin
          state_d = S_IDLE;
          done_d = 1'b1;
          case (req_q.operation)
            lph_pkg::OP_SET: begin
              mem_o.wdata.used = 1'b1;
              mem_o.wdata.key  = req_q.key_id;
              mem_o.wdata.tag  = req_q.value_tag;
              mem_o.wdata.data = req_q.value_data;
              if (hit) begin
                mem_o.we = 1'b1;
                mem_o.waddr = idx_q;
              end else if (live_q >= limit_i || !have_free) begin
                rsp_d.status = lph_pkg::ST_FULL;
              end else begin
                mem_o.we = 1'b1;
                mem_o.waddr = free_idx;
                live_d = live_q + CW'(1);
                rsp_d.live_count = live_q + CW'(1);
              end
            end
            lph_pkg::OP_GET: begin
              if (hit) begin
                rsp_d.found_key  = slot_i.key;
                rsp_d.found_tag  = slot_i.tag;
                rsp_d.found_data = slot_i.data;
              end else begin
                rsp_d.status = lph_pkg::ST_MISSING;
              end
            end
            default: begin
              if (hit) begin
                mem_o.we = 1'b1;
                mem_o.waddr = idx_q;
                mem_o.wdata = slot_i;
                mem_o.wdata.used = 1'b0;
                mem_o.wdata.tomb = 1'b1;
                if (live_q != '0) begin
                  live_d = live_q - CW'(1);
                  rsp_d.live_count = live_q - CW'(1);
                end
              end else begin
                rsp_d.status = lph_pkg::ST_MISSING;
              end
            end
          endcase
        end else begin
          idx_d = idx_q + IW'(1);
          n_d = n_q + CW'(1);
          mem_o.re = 1'b1;
          mem_o.raddr = idx_q + IW'(1);
        end
      end
      S_SCAN: begin
        rsp_d = '0;
        rsp_d.live_count = live_q;
        cur_d = cur_q + CW'(1);
        if (slot_i.used) begin
          rsp_d.status = lph_pkg::ST_OK;
          rsp_d.found_key  = slot_i.key;
          rsp_d.found_tag  = slot_i.tag;
          rsp_d.found_data = slot_i.data;
          rsp_d.next_cursor = cur_q + CW'(1);
          state_d = S_IDLE;
          done_d = 1'b1;
        end else if (cur_q == CW'(lph_pkg::CAPACITY - 1)) begin
          rsp_d.status = lph_pkg::ST_DONE;
          rsp_d.next_cursor = CW'(lph_pkg::CAPACITY);
          state_d = S_IDLE;
          done_d = 1'b1;
        end else begin
          mem_o.re = 1'b1;
          mem_o.raddr = cur_q[IW-1:0] + IW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      n_q     <= '0;
      live_q  <= '0;
      done_q  <= 1'b0;
      tomb_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      live_q  <= live_d;
      done_q  <= done_d;
      tomb_v_q <= tomb_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      req_q <= req_i;
    end
    idx_q  <= idx_d;
    cur_q  <= cur_d;
    tomb_q <= tomb_d;
    rsp_q  <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== rtl/linear_probe_hash_map.sv =====
// open-addressing key/value map with linear probing and tombstones
// request: start with req_i while busy is low; taken on that edge
// operations: set, get, delete, next-from-cursor; one result per request
// result: done_o pulses for one cycle with rsp_o valid in that cycle only
// get/set/delete do one memory read per probed slot, at most 256 slots;
// next reads slots from the cursor until a used slot or the last slot;
// a cursor at or past the end answers with no memory read
// busy stays high until the result is shown; a new request can be taken
// in the cycle done_o is high; the receiver cannot stall
// limit_we_i/limit_wdata_i write the live limit (reset 192); the user
// must write it only while idle, the block does not enforce this
// after reset a clearing pass empties every slot with busy high;
// requests are taken once busy drops
module linear_probe_hash_map (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  lph_pkg::req_t req_i,
  output logic          busy,
  output logic          done_o,
  output lph_pkg::rsp_t rsp_o,
  input  logic          limit_we_i,
  input  logic [8:0]    limit_wdata_i
);

  logic [8:0]        limit_q;
  lph_pkg::mem_req_t mem_req;
  lph_pkg::slot_t    slot_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= lph_pkg::LIMIT_RESET;
    end else if (limit_we_i) begin
      limit_q <= limit_wdata_i;
    end
  end

  lph_slot_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (slot_rd)
  );

  lph_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .req_i   (req_i),
    .limit_i (limit_q),
    .busy    (busy),
    .done_o  (done_o),
    .rsp_o   (rsp_o),
    .mem_o   (mem_req),
    .slot_i  (slot_rd)
  );

endmodule
